@@ src/acl_pkg.sv @@
package acl_pkg;

  // Field widths fixed by the item format
  localparam int SAMPLE_BITS = 12;
  localparam int DIST_W      = 16;
  localparam int MODE_W      = 2;
  localparam int STATUS_W    = 3;
  localparam int WIN_REG_W   = 7;

  // Default sizing
  localparam int DEF_MAX_POINTS = 10;
  localparam int DEF_MAX_WINDOW = 100;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIST_W;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX    = 2'd2;

  localparam logic [WIN_REG_W-1:0] WIN_RESET = 7'd10;
  localparam logic [DIST_W-1:0]    MIN_RESET = 16'd10;
  localparam logic [DIST_W-1:0]    MAX_RESET = 16'd1000;

  // Interpolation arithmetic
  localparam int DIFF_W  = DIST_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int DIV_DVD_W = 32;
  localparam int DIV_DVS_W = 16;

  // Stream payload widths
  localparam int IN_FIELDS_W  = SAMPLE_BITS + DIST_W + SAMPLE_BITS;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_SAMPLE  = 2'd0,
    MODE_INSERT  = 2'd1,
    MODE_CLEAR   = 2'd2,
    MODE_REVERSE = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NO_VALID = 3'd1,
    ST_RANGE    = 3'd2,
    ST_FULL     = 3'd3,
    ST_FEW      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    RK_CODE,
    RK_AVG,
    RK_DIST,
    RK_LEVEL
  } res_kind_t;

  typedef struct packed {
    logic [DIST_W-1:0]      dist_mm;
    logic [SAMPLE_BITS-1:0] level;
  } point_t;

  // Packed lowest field last: dist_mm ends up in the low bits
  typedef struct packed {
    logic [DIST_W-1:0]      exp_level;
    logic [SAMPLE_BITS-1:0] avg;
    logic [DIST_W-1:0]      raw;
    logic [DIST_W-1:0]      dist_mm;
  } result_t;

  localparam int OUT_FIELDS_W = $bits(result_t);
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AVG,
    S_AVG_WAIT,
    S_AVG_END,
    S_WALK_ADDR,
    S_WALK_CHK,
    S_MUL,
    S_DIV,
    S_DIV_WAIT,
    S_RES,
    S_INS_ADDR,
    S_INS_CHK,
    S_FIN
  } state_t;

  typedef struct packed {
    logic      accept;
    logic      prev_load;
    logic      seg_load;
    logic      k_inc;
    logic      k_dec;
    logic      ival_zero;
    logic      div_start;
    logic      div_interp;
    logic      raddr_prev;
    logic      ram_we;
    logic      wr_new;
    logic      ins_commit;
    logic      res_load;
    res_kind_t res_kind;
    status_t   res_code;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    mode_t in_mode;
    mode_t mode;
    logic  win_end;
    logic  none_valid;
    logic  full;
    logic  few;
    logic  k_zero;
    logic  k_last;
    logic  hit;
    logic  flat;
    logic  ins_move;
    logic  div_done;
  } dp_status_t;

endpackage

@@ src/adc_average_curve_linearizer.sv @@
// ADC averaging and calibration-curve linearizer. Mode 0 transactions carry raw
// ADC samples; after the configured window the block emits the floored average
// of the nonzero samples and converts it to a distance by interpolating over a
// stored calibration curve (walked point by point out of a small RAM), zeroing
// and flagging distances outside [min, max]. Other modes insert a calibration
// point in distance order, clear the curve, or map a distance back to an
// expected ADC level. The block works on one transaction at a time: in_tready is
// high only while idle, and a finished result still sitting in the output
// register keeps the block in its final state, with in_tready low, until out_tready
// takes it. A window end runs the shared restoring divider (one quotient bit per
// cycle) for the average before the curve walk, and an interpolated result runs
// it again; a curve lookup walks the curve point by point and an insert shifts
// points up one at a time. No clearing pass after reset; curve entries are read
// only below the point count.
module adc_average_curve_linearizer #(
  parameter int MAX_POINTS = acl_pkg::DEF_MAX_POINTS,  // curve depth, 2..32
  parameter int MAX_WINDOW = acl_pkg::DEF_MAX_WINDOW   // window clamp, 1..255
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration: 0 window_samples, 1 min_valid_distance, 2 max_valid_distance
  input  logic                            cfg_we,
  input  logic [acl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [acl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [acl_pkg::IN_TDATA_W-1:0]  in_tdata,   // sample, point_distance, point_level
  input  logic [acl_pkg::MODE_W-1:0]      in_tuser,   // mode
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [acl_pkg::OUT_TDATA_W-1:0] out_tdata,  // distance_mm, raw_distance_mm,
                                                      // average_level, expected_level, pad
  output logic [acl_pkg::STATUS_W-1:0]    out_tuser   // status
);

  // controller <-> datapath
  acl_pkg::dp_cmd_t    cmd;
  acl_pkg::dp_status_t sts;

  // sequencer: accepts a transaction, steps window end, curve walk,
  // interpolation and point insertion, then hands off to the output register
  acl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // window accumulators, curve RAM, multiplier, divider, result registers
  acl_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

@@ src/acl_ram.sv @@
module acl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/acl_div.sv @@
module acl_div #(
  parameter int DVD_W = acl_pkg::DIV_DVD_W,
  parameter int DVS_W = acl_pkg::DIV_DVS_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W+1:0] diff;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem_r, quo_r[DVD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (!diff[DVS_W+1]) begin
        rem_r <= diff[DVS_W-1:0];
        quo_r <= {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DVS_W-1:0];
        quo_r <= {quo_r[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

@@ src/acl_datapath.sv @@
module acl_datapath #(
  parameter int MAX_POINTS = acl_pkg::DEF_MAX_POINTS,
  parameter int MAX_WINDOW = acl_pkg::DEF_MAX_WINDOW
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [acl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [acl_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [acl_pkg::MODE_W-1:0]     in_tuser,
  output logic [acl_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [acl_pkg::STATUS_W-1:0]   out_tuser,
  input  acl_pkg::dp_cmd_t               cmd,
  output acl_pkg::dp_status_t            sts
);

  localparam int SB     = acl_pkg::SAMPLE_BITS;
  localparam int DW     = acl_pkg::DIST_W;
  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int WCNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SB + WCNT_W;
  localparam int WIN_CMP_W = (WCNT_W > acl_pkg::WIN_REG_W) ? WCNT_W : acl_pkg::WIN_REG_W;
  localparam int PT_W   = $bits(acl_pkg::point_t);
  localparam int PAD_W  = acl_pkg::OUT_TDATA_W - acl_pkg::OUT_FIELDS_W;

  // input fields
  logic [SB-1:0]   smp;
  logic [DW-1:0]   pd_in;
  logic [SB-1:0]   pl_in;
  acl_pkg::mode_t  in_mode;

  assign smp     = in_tdata[SB-1:0];
  assign pd_in   = in_tdata[SB +: DW];
  assign pl_in   = in_tdata[SB+DW +: SB];
  assign in_mode = acl_pkg::mode_t'(in_tuser);

  // configuration
  logic [acl_pkg::WIN_REG_W-1:0] win_cfg_r;
  logic [DW-1:0]                 min_r;
  logic [DW-1:0]                 max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cfg_r <= acl_pkg::WIN_RESET;
      min_r     <= acl_pkg::MIN_RESET;
      max_r     <= acl_pkg::MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        acl_pkg::CFG_WINDOW: win_cfg_r <= cfg_wdata[acl_pkg::WIN_REG_W-1:0];
        acl_pkg::CFG_MIN:    min_r     <= cfg_wdata;
        acl_pkg::CFG_MAX:    max_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sample window
  logic [WCNT_W-1:0]    wcnt_r;
  logic [WCNT_W-1:0]    vcnt_r;
  logic [SUM_W-1:0]     sum_r;
  logic [WCNT_W-1:0]    vcnt_nxt;
  logic [SUM_W-1:0]     sum_nxt;
  logic [WIN_CMP_W-1:0] win_ext;
  logic [WIN_CMP_W-1:0] win_cl;
  logic [WIN_CMP_W-1:0] wcnt_inc;
  logic                 smp_ok;
  logic                 win_end;

  assign win_ext  = WIN_CMP_W'(win_cfg_r);
  assign win_cl   = (win_ext == '0) ? WIN_CMP_W'(1) :
                    (win_ext > WIN_CMP_W'(MAX_WINDOW)) ? WIN_CMP_W'(MAX_WINDOW) : win_ext;
  assign wcnt_inc = WIN_CMP_W'(wcnt_r) + WIN_CMP_W'(1);
  assign win_end  = wcnt_inc >= win_cl;
  assign smp_ok   = smp != '0;
  assign vcnt_nxt = vcnt_r + WCNT_W'(smp_ok);
  assign sum_nxt  = sum_r + (smp_ok ? SUM_W'(smp) : SUM_W'(0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcnt_r <= '0;
      vcnt_r <= '0;
      sum_r  <= '0;
    end else if (cmd.accept && (in_mode == acl_pkg::MODE_SAMPLE)) begin
      wcnt_r <= win_end ? '0 : wcnt_inc[WCNT_W-1:0];
      vcnt_r <= vcnt_nxt;
      sum_r  <= sum_nxt;
    end else if (cmd.div_start && !cmd.div_interp) begin
      vcnt_r <= '0;
      sum_r  <= '0;
    end
  end

  // item registers
  acl_pkg::mode_t mode_r;
  logic [DW-1:0]  pd_r;
  logic [SB-1:0]  pl_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= in_mode;
      pd_r   <= pd_in;
      pl_r   <= pl_in;
    end
  end

  // curve bookkeeping
  logic [CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0] k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.accept && (in_mode == acl_pkg::MODE_CLEAR)) begin
      cnt_r <= '0;
    end else if (cmd.ins_commit) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (cmd.accept) begin
      k_r <= (in_mode == acl_pkg::MODE_INSERT) ? cnt_r[IDX_W-1:0] : '0;
    end else if (cmd.k_inc) begin
      k_r <= k_r + IDX_W'(1);
    end else if (cmd.k_dec) begin
      k_r <= k_r - IDX_W'(1);
    end
  end

  // curve memory
  logic [IDX_W-1:0] raddr;
  logic [PT_W-1:0]  ram_rdata;
  logic [PT_W-1:0]  ram_wdata;
  acl_pkg::point_t  cur;
  acl_pkg::point_t  new_pt;
  acl_pkg::point_t  prev_r;

  assign raddr = !cmd.raddr_prev ? k_r : ((k_r == '0) ? '0 : k_r - IDX_W'(1));
  assign new_pt.dist_mm = pd_r;
  assign new_pt.level   = pl_r;
  assign ram_wdata      = cmd.wr_new ? new_pt : ram_rdata;
  assign cur            = acl_pkg::point_t'(ram_rdata);

  acl_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_POINTS)
  ) u_curve (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (k_r),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.prev_load) begin
      prev_r <= cur;
    end
  end

  // segment select: forward walks levels, reverse walks distances
  logic            fwd;
  logic [DW-1:0]   sx, sx1, sx2, sy1, sy2;
  logic [SB-1:0]   avg_r;
  logic            hit;

  assign fwd = mode_r == acl_pkg::MODE_SAMPLE;
  assign sx  = fwd ? DW'(avg_r)        : pd_r;
  assign sx1 = fwd ? DW'(prev_r.level) : prev_r.dist_mm;
  assign sx2 = fwd ? DW'(cur.level)    : cur.dist_mm;
  assign sy1 = fwd ? prev_r.dist_mm    : DW'(prev_r.level);
  assign sy2 = fwd ? cur.dist_mm       : DW'(cur.level);
  assign hit = fwd ? ((sx <= sx1) && (sx >= sx2)) : ((sx >= sx1) && (sx <= sx2));

  // interpolation
  logic signed [acl_pkg::DIFF_W-1:0] dy_r, dx_r, den_r;
  logic signed [acl_pkg::PROD_W-1:0] prod_r;
  logic [DW-1:0]                     y1_r;
  logic [acl_pkg::PROD_W-1:0]        abs_prod;
  logic [acl_pkg::DIFF_W-1:0]        abs_den;
  logic                              neg_r;
  logic                              sel_interp_r;
  logic [acl_pkg::DIV_DVD_W-1:0]     div_dvd;
  logic [acl_pkg::DIV_DVS_W-1:0]     div_dvs;
  logic [acl_pkg::DIV_DVD_W-1:0]     div_quo;
  logic                              div_done;
  logic [DW-1:0]                     q16;
  logic [DW-1:0]                     sq;
  logic [DW-1:0]                     ival_r;

  always_ff @(posedge clk) begin
    if (cmd.seg_load) begin
      y1_r  <= sy1;
      dy_r  <= $signed({1'b0, sy2}) - $signed({1'b0, sy1});
      dx_r  <= $signed({1'b0, sx})  - $signed({1'b0, sx1});
      den_r <= $signed({1'b0, sx2}) - $signed({1'b0, sx1});
    end
    prod_r <= dy_r * dx_r;
  end

  assign abs_prod = prod_r[acl_pkg::PROD_W-1] ? acl_pkg::PROD_W'(-prod_r)
                                               : acl_pkg::PROD_W'(prod_r);
  assign abs_den  = den_r[acl_pkg::DIFF_W-1] ? acl_pkg::DIFF_W'(-den_r)
                                              : acl_pkg::DIFF_W'(den_r);
  assign div_dvd  = cmd.div_interp ? abs_prod[acl_pkg::DIV_DVD_W-1:0]
                                   : acl_pkg::DIV_DVD_W'(sum_r);
  assign div_dvs  = cmd.div_interp ? abs_den[acl_pkg::DIV_DVS_W-1:0]
                                   : acl_pkg::DIV_DVS_W'(vcnt_r);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      sel_interp_r <= cmd.div_interp;
      neg_r        <= prod_r[acl_pkg::PROD_W-1] ^ den_r[acl_pkg::DIFF_W-1];
    end
  end

  acl_div #(
    .DVD_W (acl_pkg::DIV_DVD_W),
    .DVS_W (acl_pkg::DIV_DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_quo),
    .done     (div_done)
  );

  assign q16 = div_quo[DW-1:0];
  assign sq  = neg_r ? (DW'(0) - q16) : q16;

  always_ff @(posedge clk) begin
    if (cmd.seg_load) begin
      ival_r <= sy1;
    end else if (cmd.ival_zero) begin
      ival_r <= '0;
    end else if (div_done && sel_interp_r) begin
      ival_r <= y1_r + sq;
    end
  end

  always_ff @(posedge clk) begin
    if (div_done && !sel_interp_r) begin
      avg_r <= div_quo[SB-1:0];
    end
  end

  // result staging and output register
  acl_pkg::result_t res_r;
  acl_pkg::status_t res_st_r;
  acl_pkg::result_t out_res_r;
  acl_pkg::status_t out_st_r;
  logic             oor;

  assign oor = (ival_r < min_r) || (ival_r > max_r);

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_r    <= '0;
      res_st_r <= acl_pkg::ST_OK;
      case (cmd.res_kind)
        acl_pkg::RK_CODE: begin
          res_st_r <= cmd.res_code;
        end
        acl_pkg::RK_AVG: begin
          res_r.avg <= avg_r;
          res_st_r  <= acl_pkg::ST_FEW;
        end
        acl_pkg::RK_DIST: begin
          res_r.avg     <= avg_r;
          res_r.raw     <= ival_r;
          res_r.dist_mm <= oor ? '0 : ival_r;
          res_st_r      <= oor ? acl_pkg::ST_RANGE : acl_pkg::ST_OK;
        end
        default: begin
          res_r.exp_level <= ival_r;
        end
      endcase
    end
    if (cmd.out_load) begin
      out_res_r <= res_r;
      out_st_r  <= res_st_r;
    end
  end

  assign out_tdata = {{PAD_W{1'b0}}, out_res_r};
  assign out_tuser = out_st_r;

  // status to controller
  assign sts.in_mode    = in_mode;
  assign sts.mode       = mode_r;
  assign sts.win_end    = win_end;
  assign sts.none_valid = vcnt_nxt == '0;
  assign sts.full       = cnt_r >= CNT_W'(MAX_POINTS);
  assign sts.few        = cnt_r < CNT_W'(2);
  assign sts.k_zero     = k_r == '0;
  assign sts.k_last     = (CNT_W'(k_r) + CNT_W'(1)) == cnt_r;
  assign sts.hit        = hit;
  assign sts.flat       = sx1 == sx2;
  assign sts.ins_move   = (k_r != '0) && (cur.dist_mm > pd_r);
  assign sts.div_done   = div_done;

endmodule

@@ src/acl_ctrl.sv @@
module acl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  acl_pkg::dp_status_t sts,
  output acl_pkg::dp_cmd_t    cmd
);

  acl_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= acl_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  assign out_tvalid    = out_valid_r;
  assign in_tready     = state_r == acl_pkg::S_IDLE;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      acl_pkg::S_IDLE: begin
        if (in_tvalid) begin
          case (sts.in_mode)
            acl_pkg::MODE_SAMPLE: begin
              if (sts.win_end) begin
                state_nxt = sts.none_valid ? acl_pkg::S_FIN : acl_pkg::S_AVG;
              end
            end
            acl_pkg::MODE_INSERT: begin
              state_nxt = sts.full ? acl_pkg::S_FIN : acl_pkg::S_INS_ADDR;
            end
            acl_pkg::MODE_CLEAR: begin
              state_nxt = acl_pkg::S_FIN;
            end
            default: begin
              state_nxt = sts.few ? acl_pkg::S_FIN : acl_pkg::S_WALK_ADDR;
            end
          endcase
        end
      end
      acl_pkg::S_AVG:      state_nxt = acl_pkg::S_AVG_WAIT;
      acl_pkg::S_AVG_WAIT: begin
        if (sts.div_done) begin
          state_nxt = acl_pkg::S_AVG_END;
        end
      end
      acl_pkg::S_AVG_END: begin
        state_nxt = sts.few ? acl_pkg::S_FIN : acl_pkg::S_WALK_ADDR;
      end
      acl_pkg::S_WALK_ADDR: state_nxt = acl_pkg::S_WALK_CHK;
      acl_pkg::S_WALK_CHK: begin
        if (sts.k_zero) begin
          state_nxt = acl_pkg::S_WALK_ADDR;
        end else if (sts.hit) begin
          state_nxt = sts.flat ? acl_pkg::S_RES : acl_pkg::S_MUL;
        end else if (sts.k_last) begin
          state_nxt = (sts.mode == acl_pkg::MODE_SAMPLE) ? acl_pkg::S_RES : acl_pkg::S_FIN;
        end else begin
          state_nxt = acl_pkg::S_WALK_ADDR;
        end
      end
      acl_pkg::S_MUL:      state_nxt = acl_pkg::S_DIV;
      acl_pkg::S_DIV:      state_nxt = acl_pkg::S_DIV_WAIT;
      acl_pkg::S_DIV_WAIT: begin
        if (sts.div_done) begin
          state_nxt = acl_pkg::S_RES;
        end
      end
      acl_pkg::S_RES:      state_nxt = acl_pkg::S_FIN;
      acl_pkg::S_INS_ADDR: state_nxt = acl_pkg::S_INS_CHK;
      acl_pkg::S_INS_CHK: begin
        state_nxt = sts.ins_move ? acl_pkg::S_INS_ADDR : acl_pkg::S_FIN;
      end
      acl_pkg::S_FIN: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = acl_pkg::S_IDLE;
        end
      end
      default: state_nxt = acl_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd          = '0;
    cmd.res_kind = acl_pkg::RK_CODE;
    cmd.res_code = acl_pkg::ST_OK;
    unique case (state_r)
      acl_pkg::S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          case (sts.in_mode)
            acl_pkg::MODE_SAMPLE: begin
              if (sts.win_end && sts.none_valid) begin
                cmd.res_load = 1'b1;
                cmd.res_code = acl_pkg::ST_NO_VALID;
              end
            end
            acl_pkg::MODE_INSERT: begin
              if (sts.full) begin
                cmd.res_load = 1'b1;
                cmd.res_code = acl_pkg::ST_FULL;
              end
            end
            acl_pkg::MODE_CLEAR: begin
              cmd.res_load = 1'b1;
            end
            default: begin
              if (sts.few) begin
                cmd.res_load = 1'b1;
                cmd.res_code = acl_pkg::ST_FEW;
              end
            end
          endcase
        end
      end
      acl_pkg::S_AVG: begin
        cmd.div_start = 1'b1;
      end
      acl_pkg::S_AVG_END: begin
        if (sts.few) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = acl_pkg::RK_AVG;
        end
      end
      acl_pkg::S_WALK_CHK: begin
        if (sts.k_zero) begin
          cmd.prev_load = 1'b1;
          cmd.k_inc     = 1'b1;
        end else if (sts.hit) begin
          cmd.seg_load = 1'b1;
        end else begin
          cmd.prev_load = 1'b1;
          cmd.k_inc     = 1'b1;
          if (sts.k_last) begin
            if (sts.mode == acl_pkg::MODE_SAMPLE) begin
              cmd.ival_zero = 1'b1;
            end else begin
              cmd.res_load = 1'b1;
              cmd.res_code = acl_pkg::ST_RANGE;
            end
          end
        end
      end
      acl_pkg::S_DIV: begin
        cmd.div_start  = 1'b1;
        cmd.div_interp = 1'b1;
      end
      acl_pkg::S_RES: begin
        cmd.res_load = 1'b1;
        cmd.res_kind = (sts.mode == acl_pkg::MODE_SAMPLE) ? acl_pkg::RK_DIST
                                                          : acl_pkg::RK_LEVEL;
      end
      acl_pkg::S_INS_ADDR: begin
        cmd.raddr_prev = 1'b1;
      end
      acl_pkg::S_INS_CHK: begin
        cmd.ram_we = 1'b1;
        if (sts.ins_move) begin
          cmd.k_dec = 1'b1;
        end else begin
          cmd.wr_new     = 1'b1;
          cmd.ins_commit = 1'b1;
          cmd.res_load   = 1'b1;
        end
      end
      acl_pkg::S_FIN: begin
        cmd.out_load = !out_valid_r || out_tready;
      end
      default: ;
    endcase
  end

endmodule
